/* rtl/masked_byte_pattern_scanner_macros.svh */
// Assertion macros for the masked byte pattern scanner.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`ifndef ASSERT_OFF
`define SCAN_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");
`define SCAN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");
`else
`define SCAN_ASSERT_SAME(name, ante, cons)
`define SCAN_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern scanner.
// No dependencies.
`default_nettype none
package mbps_pkg;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_REGS   = 4;
    localparam int PAT_BYTES  = 32;
    localparam int PLEN_W     = 6;
    localparam int STEP_W     = 5;
    localparam int PHASE_W    = 4;
    localparam int STEP_MAX   = 16;
    localparam int RESULT_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_CARE      = 3'd4,
        CFG_PLEN      = 3'd5,
        CFG_STEP      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data;
        logic       aligned;
    } t_cell_data;
endpackage
`default_nettype wire

/* rtl/mbps_cell.sv */
// One window cell: holds a byte and its alignment flag, shifts them on to the
// next cell, and compares its byte with the pattern byte routed to it. Uses mbps_pkg.
`default_nettype none
module mbps_cell (
    input  wire                 i_clk,
    input  wire                 i_shift,
    input  mbps_pkg::t_cell_data i_prev,
    input  wire  [7:0]          i_pat,
    input  wire                 i_care,
    output mbps_pkg::t_cell_data o_cell,
    output logic                o_match
);
    import mbps_pkg::*;

    t_cell_data r_cell;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_cell <= i_prev;
        end
    end

    assign o_cell  = r_cell;
    assign o_match = !i_care || (r_cell.data == i_pat);
endmodule
`default_nettype wire

/* rtl/masked_byte_pattern_scanner.sv */
// Top level of the masked byte pattern scanner: configuration registers,
// stride and offset tracking, the chain of window cells and the result stage.
// Uses mbps_pkg, mbps_cell and masked_byte_pattern_scanner_macros.svh.
//
//  Channel   Direction  Word
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata[31:0] match_offset, tuser found
//  cfg       in         i_cfg_we, i_cfg_addr register index, i_cfg_wdata
//
// One byte is taken every cycle while the output is not stalled. A byte
// enters the cell chain when accepted, is compared in the next cycle and its
// result is registered at the output. Reset clears control state. A stalled
// output holds the compare stage, and the input stalls with it.
`default_nettype none
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int OFFSET_BITS       = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [7:0]                     s_axis_tdata,   // data_byte
    input  wire                            s_axis_tlast,   // last_byte
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [mbps_pkg::RESULT_W-1:0]  m_axis_tdata,   // match_offset
    output logic                           m_axis_tuser,   // found
    input  wire                            i_cfg_we,
    input  wire  [mbps_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire  [mbps_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mbps_pkg::*;

    localparam int CAP    = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;
    localparam int SUM_W  = OFFSET_BITS + 1;
    localparam int WIDE_W = OFFSET_BITS + RESULT_W + 1;

    logic [CFG_DATA_W-1:0] r_pat [PAT_REGS];
    logic [PAT_BYTES-1:0]  r_care;
    logic [PLEN_W-1:0]     r_plen;
    logic [STEP_W-1:0]     r_step;

    logic [OFFSET_BITS-1:0] r_count;
    logic [PHASE_W-1:0]     r_phase;
    logic                   r_match;
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [OFFSET_BITS-1:0] r_s1_cnt;
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [RESULT_W-1:0]    r_out_offset;

    logic [PLEN_W-1:0]      len_eff;
    logic [STEP_W-1:0]      step_eff;
    logic [STEP_W-1:0]      phase_inc;
    logic [PHASE_W-1:0]     n_phase;
    logic                   in_fire;
    logic                   s1_adv;
    logic [8*PAT_BYTES-1:0] pat_flat;
    logic [7:0]             cell_pat  [CAP];
    logic                   cell_care [CAP];
    logic                   cell_eq   [CAP];
    t_cell_data             chain     [CAP+1];
    logic                   all_eq;
    logic                   sel_flag;
    logic [SUM_W-1:0]       cnt_sum;
    logic                   cnt_ok;
    logic                   hit;
    logic                   produce;
    logic [WIDE_W-1:0]      off_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_care   <= '1;
            r_plen   <= PLEN_W'(1);
            r_step   <= STEP_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PAT_0_7:   r_pat[0] <= i_cfg_wdata;
                CFG_PAT_8_15:  r_pat[1] <= i_cfg_wdata;
                CFG_PAT_16_23: r_pat[2] <= i_cfg_wdata;
                CFG_PAT_24_31: r_pat[3] <= i_cfg_wdata;
                CFG_CARE:      r_care   <= i_cfg_wdata[PAT_BYTES-1:0];
                CFG_PLEN:      r_plen   <= i_cfg_wdata[PLEN_W-1:0];
                CFG_STEP:      r_step   <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_plen == '0) begin
            len_eff = PLEN_W'(1);
        end else if (r_plen > PLEN_W'(CAP)) begin
            len_eff = PLEN_W'(CAP);
        end else begin
            len_eff = r_plen;
        end
        if (r_step == '0) begin
            step_eff = STEP_W'(1);
        end else if (r_step > STEP_W'(STEP_MAX)) begin
            step_eff = STEP_W'(STEP_MAX);
        end else begin
            step_eff = r_step;
        end
    end

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign phase_inc     = {1'b0, r_phase} + STEP_W'(1);
    assign n_phase       = (phase_inc >= step_eff) ? '0 : phase_inc[PHASE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
        end else if (in_fire) begin
            if (s_axis_tlast) begin
                r_count <= '0;
                r_phase <= '0;
            end else begin
                r_count <= (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);
                r_phase <= n_phase;
            end
        end
    end

    assign chain[0] = '{data: s_axis_tdata, aligned: (r_phase == '0)};
    assign pat_flat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    always_comb begin
        logic [PLEN_W-1:0] idx;
        for (int j = 0; j < CAP; j++) begin
            idx          = len_eff - PLEN_W'(j) - PLEN_W'(1);
            cell_pat[j]  = pat_flat[8*idx[4:0] +: 8];
            cell_care[j] = (PLEN_W'(j) < len_eff) && r_care[idx[4:0]];
        end
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (in_fire),
            .i_prev  (chain[g]),
            .i_pat   (cell_pat[g]),
            .i_care  (cell_care[g]),
            .o_cell  (chain[g+1]),
            .o_match (cell_eq[g])
        );
    end

    always_comb begin
        all_eq   = 1'b1;
        sel_flag = 1'b0;
        for (int j = 0; j < CAP; j++) begin
            all_eq   = all_eq && cell_eq[j];
            sel_flag = sel_flag || (chain[j+1].aligned && (PLEN_W'(j) == len_eff - PLEN_W'(1)));
        end
    end

    assign cnt_sum  = {1'b0, r_s1_cnt} + SUM_W'(1);
    assign cnt_ok   = cnt_sum >= SUM_W'(len_eff);
    assign hit      = !r_match && cnt_ok && sel_flag && all_eq;
    assign produce  = hit || (r_s1_last && !r_match);
    assign off_wide = WIDE_W'(cnt_sum - SUM_W'(len_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_match    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_last) begin
                    r_match <= 1'b0;
                end else if (hit) begin
                    r_match <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last <= s_axis_tlast;
            r_s1_cnt  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && produce) begin
            r_out_found  <= hit;
            r_out_offset <= hit ? off_wide[RESULT_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

`include "masked_byte_pattern_scanner_macros.svh"

    `SCAN_ASSERT_SAME(a_chain_holds, r_s1_valid && !s1_adv, !s_axis_tready)
    `SCAN_ASSERT_NEXT(a_hit_sets_match, s1_adv && hit && !r_s1_last, r_match)
    `SCAN_ASSERT_NEXT(a_last_clears, in_fire && s_axis_tlast, r_count == '0 && r_phase == '0)
    `SCAN_ASSERT_SAME(a_one_result, r_match && r_s1_valid, !hit)
endmodule
`default_nettype wire

/* bench/masked_byte_pattern_scanner_tb.sv */
// Testbench for masked_byte_pattern_scanner: drives byte buffers with planted and broken
// signatures under random register settings and checks result words against a built-in
// scan predictor or directed expected values. Depends on mbps_pkg and the scanner RTL.
module masked_byte_pattern_scanner_tb;
    import mbps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 1500;
    localparam int CALM_AFTER   = 1200;

    typedef enum logic {ROW_CFG, ROW_BYTE} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_HIT, CHK_MISS} t_row_check;

    typedef struct packed {
        t_row_kind  kind;
        t_cfg_idx   reg_idx;
        logic [63:0] reg_val;
        logic [7:0] data;
        logic       last;
        t_row_check check;
        logic [31:0] offset;
    } t_row;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } t_scan_result;

    localparam int DIRECTED_ROWS = 26;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h00, 1'b0, CHK_HIT,   32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'hFF, 1'b1, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'hFF, 1'b1, CHK_MISS,  32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'hFF, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h00, 1'b1, CHK_HIT,   32'd1},
        '{ROW_CFG,  CFG_PAT_0_7, 64'hFFFF_FFFF_FF56_3412, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_CFG,  CFG_PLEN,    64'd3, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h12, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h34, 1'b1, CHK_MISS,  32'd0},
        '{ROW_CFG,  CFG_CARE,    64'hFFFF_FFFD, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h12, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'hAB, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h56, 1'b0, CHK_HIT,   32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h00, 1'b1, CHK_MODEL, 32'd0},
        '{ROW_CFG,  CFG_STEP,    64'd2, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h99, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h12, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h56, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h12, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h77, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h56, 1'b1, CHK_HIT,   32'd4},
        '{ROW_CFG,  CFG_PLEN,    64'd0, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_CFG,  CFG_STEP,    64'd0, 8'h00, 1'b0, CHK_MODEL, 32'd0},
        '{ROW_BYTE, CFG_PAT_0_7, 64'h0, 8'h12, 1'b1, CHK_HIT,   32'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [RESULT_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_addr = CFG_PAT_0_7;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Register shadow and scan state of the predictor.
    logic [63:0] sig_word [PAT_REGS] = '{default: '0};
    logic [31:0] care_bits = '1;
    logic [5:0]  sig_len = 6'd1;
    logic [4:0]  stride_cfg = 5'd1;
    logic [7:0]  hist_byte [PAT_BYTES];
    bit          hist_start [PAT_BYTES];
    logic [31:0] seen_count;
    logic [3:0]  phase_cnt;
    bit          hit_done;

    t_scan_result pending_results [$];
    int          mismatch_cnt = 0;
    int          bytes_sent = 0;
    int          src_gap_pct = 25;
    int          snk_stall_pct = 25;
    bit          calm = 1'b0;
    int          sink_hold = 0;
    int unsigned cycle_cnt = 0;

    masked_byte_pattern_scanner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // data_byte
        .s_axis_tlast  (s_axis_tlast),   // last_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // match_offset
        .m_axis_tuser  (m_axis_tuser),   // found
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_scan();
        int i;
        for (i = 0; i < PAT_BYTES; i++) begin
            hist_byte[i] = '0;
            hist_start[i] = 1'b0;
        end
        seen_count = '0;
        phase_cnt = '0;
        hit_done = 1'b0;
    endfunction

    function automatic int effective_len();
        int l;
        l = sig_len;
        if (l == 0) l = 1;
        if (l > PAT_BYTES) l = PAT_BYTES;
        return l;
    endfunction

    function automatic int effective_step();
        int s;
        s = stride_cfg;
        if (s == 0) s = 1;
        if (s > STEP_MAX) s = STEP_MAX;
        return s;
    endfunction

    function automatic logic [7:0] sig_byte(input int i);
        return sig_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Shifts one byte into the window and returns 1 when it yields a result word.
    function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                     output t_scan_result res);
        int len;
        int stp;
        int i;
        bit hit;
        bit got;
        logic [63:0] n_next;
        len = effective_len();
        stp = effective_step();
        got = 1'b0;
        res = '0;
        for (i = PAT_BYTES - 1; i > 0; i--) begin
            hist_byte[i] = hist_byte[i - 1];
            hist_start[i] = hist_start[i - 1];
        end
        hist_byte[0] = b;
        hist_start[0] = (phase_cnt == 0);
        if (int'(phase_cnt) + 1 >= stp) phase_cnt = '0;
        else phase_cnt = phase_cnt + 4'd1;
        n_next = 64'(seen_count) + 64'd1;
        if (!hit_done && n_next >= 64'(len) && hist_start[len - 1]) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
                if (care_bits[i] && sig_byte(i) != hist_byte[len - 1 - i]) hit = 1'b0;
            end
            if (hit) begin
                hit_done = 1'b1;
                res.found = 1'b1;
                res.offset = 32'(n_next - 64'(len));
                got = 1'b1;
            end
        end
        if (seen_count != '1) seen_count = seen_count + 32'd1;
        if (last) begin
            if (!hit_done) begin
                res = '0;
                got = 1'b1;
            end
            clear_scan();
        end
        return got;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at cycle %0d: %s, expected %0h, got %0h",
                 cycle_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    // Leaves the write enable high; the next byte or a following write takes it over.
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        case (idx)
            CFG_PAT_0_7:   sig_word[0] = v;
            CFG_PAT_8_15:  sig_word[1] = v;
            CFG_PAT_16_23: sig_word[2] = v;
            CFG_PAT_24_31: sig_word[3] = v;
            CFG_CARE:      care_bits = v[31:0];
            CFG_PLEN:      sig_len = v[5:0];
            CFG_STEP:      stride_cfg = v[4:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input t_row_check chk,
                             input logic [31:0] typed_off);
        t_scan_result res;
        bit got;
        i_cfg_we <= 1'b0;
        if (!calm && src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        got = scan_byte(b, last, res);
        case (chk)
            CHK_HIT:  pending_results.push_back(t_scan_result'{1'b1, typed_off});
            CHK_MISS: pending_results.push_back(t_scan_result'{1'b0, 32'd0});
            default:  if (got) pending_results.push_back(res);
        endcase
        bytes_sent++;
    endtask

    function automatic logic [63:0] rand_pattern_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic configure_random(input int phase_no);
        logic [63:0] words [PAT_REGS];
        logic [31:0] care;
        logic [5:0]  plen;
        logic [4:0]  stp;
        int i;
        for (i = 0; i < PAT_REGS; i++) words[i] = rand_pattern_word();
        case ($urandom_range(0, 9))
            0:       care = '1;
            1:       care = '0;
            2, 3, 4: care = $urandom;
            default: care = ~((32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)));
        endcase
        case ($urandom_range(0, 9))
            0:       plen = 6'd0;
            1:       plen = 6'($urandom_range(33, 63));
            2:       plen = 6'd32;
            3:       plen = 6'($urandom_range(9, 31));
            default: plen = 6'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       stp = 5'd0;
            1:       stp = 5'($urandom_range(17, 31));
            2:       stp = 5'd16;
            default: stp = 5'($urandom_range(1, 4));
        endcase
        // The first phases pin the register extremes.
        case (phase_no)
            0: begin
                plen = 6'h3F;
                stp = 5'h1F;
            end
            1: begin
                plen = 6'd32;
                stp = 5'd16;
                care = '1;
            end
            2: begin
                plen = 6'd0;
                stp = 5'd0;
                care = '0;
            end
            3: begin
                plen = 6'd1;
                stp = 5'd1;
                for (i = 0; i < PAT_REGS; i++) words[i] = '1;
            end
            default: ;
        endcase
        settle();
        write_reg(CFG_PAT_0_7, words[0]);
        write_reg(CFG_PAT_8_15, words[1]);
        write_reg(CFG_PAT_16_23, words[2]);
        write_reg(CFG_PAT_24_31, words[3]);
        write_reg(CFG_CARE, 64'(care));
        write_reg(CFG_PLEN, 64'(plen));
        write_reg(CFG_STEP, 64'(stp));
    endtask

    // One buffer: background bytes drawn partly from the signature, then a planted copy
    // at an aligned, final, unaligned or corrupted position, or none at all.
    task automatic send_buffer();
        logic [7:0] frame_bytes [$];
        int len;
        int stp;
        int blen;
        int start;
        int plant;
        int i;
        len = effective_len();
        stp = effective_step();
        case ($urandom_range(0, 9))
            0:       blen = (len > 1) ? $urandom_range(1, len - 1) : 1;
            1:       blen = len + $urandom_range(40, 80);
            default: blen = len + $urandom_range(0, 16);
        endcase
        for (i = 0; i < blen; i++) begin
            if ($urandom_range(0, 1) == 0) frame_bytes.push_back(8'($urandom));
            else frame_bytes.push_back(sig_byte($urandom_range(0, len - 1)));
        end
        plant = $urandom_range(0, 9);
        if (blen >= len && plant != 9) begin
            case (plant)
                6:       start = ((blen - len) / stp) * stp;
                7:       start = $urandom_range(0, blen - len);
                default: start = $urandom_range(0, (blen - len) / stp) * stp;
            endcase
            for (i = 0; i < len; i++) begin
                if (care_bits[i]) frame_bytes[start + i] = sig_byte(i);
            end
            if (plant == 8) begin
                i = $urandom_range(0, len - 1);
                frame_bytes[start + i] ^= 8'd1 << $urandom_range(0, 7);
            end
        end
        for (i = 0; i < blen; i++)
            send_byte(frame_bytes[i], i == blen - 1, CHK_MODEL, 32'd0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm || snk_stall_pct == 0) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 99) < snk_stall_pct) begin
            m_axis_tready <= 1'b0;
            sink_hold <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with none pending", 32'd0, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch("found flag", 32'(want.found), 32'(m_axis_tuser));
                if (m_axis_tdata !== want.offset)
                    report_mismatch("match offset", want.offset, m_axis_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row row;
        bit prev_cfg;
        int phase_no;
        clear_scan();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                write_reg(row.reg_idx, row.reg_val);
                prev_cfg = 1'b1;
            end else begin
                send_byte(row.data, row.last, row.check, row.offset);
                prev_cfg = 1'b0;
            end
        end

        phase_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            calm = (bytes_sent >= CALM_AFTER);
            case ($urandom_range(0, 2))
                0:       src_gap_pct = 0;
                1:       src_gap_pct = 15;
                default: src_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       snk_stall_pct = 0;
                1:       snk_stall_pct = 15;
                default: snk_stall_pct = 40;
            endcase
            configure_random(phase_no);
            repeat (4) send_buffer();
            phase_no++;
        end

        calm = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
